>>> sv/mnva_pkg.sv
package mnva_pkg;

	// action codes
	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_TRI    = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// result kinds
	localparam logic KIND_FACE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam int DEF_VERTEX_DEPTH = 1024;
	localparam logic [7:0] COUNT_MAX = 8'd255;

	typedef struct packed {
		logic [1:0]         action;
		logic [9:0]         vertex_index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [9:0]         corner_a;
		logic [9:0]         corner_b;
		logic [9:0]         corner_c;
	} item_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic               is_line;
		logic [7:0]         share_count;
	} result_t;

endpackage

>>> sv/mesh_vertex_normal_accumulator.sv
// Vertex store with running-average normals. A write request stores a vertex
// and clears its normal and count as it is accepted. A read request places
// the stored normal and share count in the output register by way of the
// store's read register and a pending result register. In a triangle
// request, one shared 32x32 multiplier forms the cross product, the squares
// and the averaging products, a normalizing shift of one bit per cycle, a
// two-bit-per-cycle square root and a shared restoring divider run in turn
// (the face divisions are skipped when the cross product is zero), and each
// corner's normal is read, updated and written back through the store's read
// and write ports.
// The block takes no new request until the current one has finished and its
// result is placed in the output register; a waiting result does not block
// the next request. Corner indices of VERTEX_DEPTH or more drop the triangle.
module mesh_vertex_normal_accumulator #(
	parameter int VERTEX_DEPTH = mnva_pkg::DEF_VERTEX_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  mnva_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output mnva_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam logic [4:0] CROSS_LAST = 5'd6;
	localparam logic [4:0] SQ_LAST    = 5'd3;
	localparam logic [4:0] SQRT_LAST  = 5'd31;
	localparam logic [4:0] DIV_LAST   = 5'd14;

	typedef enum logic [4:0] {
		S_IDLE, S_RD_OUT, S_RD_A, S_RD_B, S_RD_C, S_LOAD_C, S_EDGE, S_ESHIFT,
		S_CROSS, S_CMAG, S_CSHIFT, S_SQ, S_SQRT, S_DSET, S_DRUN,
		S_FRD, S_FCAP, S_FMUL, S_FADD, S_FDIV, S_FWR, S_EMIT
	} state_t;

	function automatic logic idx_ok(input logic [9:0] idx);
		return ({22'd0, idx} < 32'(VERTEX_DEPTH));
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [9:0] idx);
		return AW'(idx);
	endfunction

	state_t            state_q;
	logic [4:0]        step_q;
	logic [1:0]        comp_q;
	logic [1:0]        vtx_q;
	logic              pos_q;
	mnva_pkg::result_t pend_q;

	// storage
	logic [95:0] pos_mem [VERTEX_DEPTH];
	logic [55:0] nrm_mem [VERTEX_DEPTH];
	logic [95:0] pos_rd_q;
	logic [55:0] nrm_rd_q;
	logic [AW-1:0] pos_raddr, nrm_raddr, nrm_waddr;
	logic          nrm_we;
	logic [55:0]   nrm_wdata;

	// datapath registers
	mnva_pkg::item_t    item_q;
	logic [95:0]        pa_q, pb_q;
	logic               line_q;
	logic signed [32:0] eg_q [6];
	logic signed [30:0] es_q [6];
	logic signed [63:0] cr_q [3];
	logic [61:0]        cm_q [3];
	logic [2:0]         cs_q;
	logic [63:0]        sum_q;
	logic [63:0]        sx_q;
	logic [35:0]        srem_q;
	logic [31:0]        sroot_q;
	logic [47:0]        drem_q, dden_q;
	logic [14:0]        dquo_q;
	logic signed [15:0] face_q [3];
	logic signed [15:0] nav_q [3];
	logic [7:0]         ncnt_q;
	logic               fsign_q;
	logic signed [63:0] prod_q;

	logic signed [31:0] mul_a, mul_b;
	logic [9:0]         corner_sel;
	logic               accept;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_CROSS: begin
				unique case (step_q[2:0])
					3'd0: begin mul_a = 32'(es_q[1]); mul_b = 32'(es_q[5]); end
					3'd1: begin mul_a = 32'(es_q[2]); mul_b = 32'(es_q[4]); end
					3'd2: begin mul_a = 32'(es_q[2]); mul_b = 32'(es_q[3]); end
					3'd3: begin mul_a = 32'(es_q[0]); mul_b = 32'(es_q[5]); end
					3'd4: begin mul_a = 32'(es_q[0]); mul_b = 32'(es_q[4]); end
					3'd5: begin mul_a = 32'(es_q[1]); mul_b = 32'(es_q[3]); end
					default: ;
				endcase
			end
			S_SQ: begin
				if (step_q[1:0] != 2'd3) begin
					mul_a = {2'b00, cm_q[step_q[1:0]][29:0]};
					mul_b = {2'b00, cm_q[step_q[1:0]][29:0]};
				end
			end
			S_FMUL: begin
				mul_a = 32'(nav_q[comp_q]);
				mul_b = {24'd0, ncnt_q};
			end
			default: ;
		endcase
	end

	// corner of the fold pass
	always_comb begin
		unique case (vtx_q)
			2'd0:    corner_sel = item_q.corner_a;
			2'd1:    corner_sel = item_q.corner_b;
			default: corner_sel = item_q.corner_c;
		endcase
	end

	// store addresses and write port
	always_comb begin
		pos_raddr = '0;
		unique case (state_q)
			S_RD_A:  pos_raddr = to_addr(item_q.corner_a);
			S_RD_B:  pos_raddr = to_addr(item_q.corner_b);
			S_RD_C:  pos_raddr = to_addr(item_q.corner_c);
			default: ;
		endcase
		nrm_raddr = (state_q == S_FRD) ? to_addr(corner_sel) : to_addr(item.vertex_index);
		nrm_we    = 1'b0;
		nrm_waddr = to_addr(item.vertex_index);
		nrm_wdata = '0;
		if (accept && item.action == mnva_pkg::ACT_WRITE && idx_ok(item.vertex_index)) begin
			nrm_we = 1'b1;
		end else if (state_q == S_FWR) begin
			nrm_we    = 1'b1;
			nrm_waddr = to_addr(corner_sel);
			nrm_wdata = {(ncnt_q == mnva_pkg::COUNT_MAX) ? ncnt_q : ncnt_q + 8'd1,
				nav_q[2], nav_q[1], nav_q[0]};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.action == mnva_pkg::ACT_WRITE && idx_ok(item.vertex_index))
			pos_mem[to_addr(item.vertex_index)] <= {item.coord_z, item.coord_y, item.coord_x};
		pos_rd_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (nrm_we)
			nrm_mem[nrm_waddr] <= nrm_wdata;
		nrm_rd_q <= nrm_mem[nrm_raddr];
	end

	// edge magnitudes and first fit shift
	logic [32:0] emag [6];
	logic [32:0] eor;
	logic [1:0]  esh;
	always_comb begin
		eor = '0;
		for (int i = 0; i < 6; i++) begin
			emag[i] = eg_q[i][32] ? 33'(-eg_q[i]) : 33'(eg_q[i]);
			eor     = eor | emag[i];
		end
		priority if (eor[32]) esh = 2'd3;
		else if (eor[31])     esh = 2'd2;
		else if (eor[30])     esh = 2'd1;
		else                  esh = 2'd0;
	end

	// cross-product accumulate slot
	logic [2:0] cp;
	assign cp = step_q[2:0] - 3'd1;

	logic [61:0] cor;
	assign cor = cm_q[0] | cm_q[1] | cm_q[2];

	// square root step
	logic [35:0] srem2, strial;
	logic        sge;
	assign srem2  = {srem_q[33:0], sx_q[63:62]};
	assign strial = {2'b00, sroot_q, 2'b01};
	assign sge    = (srem2 >= strial);

	// divider step
	logic        dge;
	logic [14:0] dquo_nx;
	logic signed [15:0] q16;
	assign dge     = (drem_q >= dden_q);
	assign dquo_nx = {dquo_q[13:0], dge};
	assign q16     = $signed({1'b0, dquo_nx});

	// averaging sum
	logic signed [63:0] fsum;
	logic [63:0]        fmag;
	logic [8:0]         fden;
	assign fsum = prod_q + 64'(face_q[comp_q]);
	assign fmag = fsum[63] ? 64'(-fsum) : 64'(fsum);
	assign fden = {1'b0, ncnt_q} + 9'd1;

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept)
			item_q <= item;
		unique case (state_q)
			S_RD_B: pa_q <= pos_rd_q;
			S_RD_C: pb_q <= pos_rd_q;
			S_LOAD_C: begin
				line_q <= (pb_q == pos_rd_q);
				for (int i = 0; i < 3; i++) begin
					eg_q[i]   <= $signed({pb_q[32*i+31], pb_q[32*i +: 32]})
						- $signed({pa_q[32*i+31], pa_q[32*i +: 32]});
					eg_q[i+3] <= $signed({pos_rd_q[32*i+31], pos_rd_q[32*i +: 32]})
						- $signed({pa_q[32*i+31], pa_q[32*i +: 32]});
				end
			end
			S_ESHIFT: begin
				for (int i = 0; i < 6; i++)
					es_q[i] <= eg_q[i][32] ? -$signed(31'(emag[i] >> esh))
						: $signed(31'(emag[i] >> esh));
			end
			S_CROSS: begin
				if (step_q != 5'd0) begin
					if (!cp[0]) cr_q[cp[2:1]] <= prod_q;
					else        cr_q[cp[2:1]] <= cr_q[cp[2:1]] - prod_q;
				end
			end
			S_CMAG: begin
				for (int i = 0; i < 3; i++) begin
					cm_q[i] <= cr_q[i][63] ? 62'(-cr_q[i]) : 62'(cr_q[i]);
					cs_q[i] <= cr_q[i][63];
				end
			end
			S_CSHIFT: begin
				if (cor[61:30] != '0)
					for (int i = 0; i < 3; i++) cm_q[i] <= cm_q[i] >> 1;
			end
			S_SQ: begin
				if (step_q == 5'd0) sum_q <= '0;
				else                sum_q <= sum_q + 64'(prod_q);
				if (step_q == SQ_LAST) begin
					sx_q    <= sum_q + 64'(prod_q);
					srem_q  <= '0;
					sroot_q <= '0;
				end
			end
			S_SQRT: begin
				srem_q  <= sge ? srem2 - strial : srem2;
				sroot_q <= {sroot_q[30:0], sge};
				sx_q    <= sx_q << 2;
			end
			S_DSET: begin
				if (sroot_q == '0) begin
					for (int i = 0; i < 3; i++) face_q[i] <= '0;
				end else begin
					drem_q <= (48'(cm_q[comp_q][29:0]) << 15) + 48'(sroot_q);
					dden_q <= 48'(sroot_q) << 15;
					dquo_q <= '0;
				end
			end
			S_DRUN: begin
				if (dge) drem_q <= drem_q - dden_q;
				dden_q <= dden_q >> 1;
				dquo_q <= dquo_nx;
				if (step_q == DIV_LAST)
					face_q[comp_q] <= (cs_q[comp_q] ^ !pos_q) ? -q16 : q16;
			end
			S_FCAP: begin
				nav_q[0] <= $signed(nrm_rd_q[15:0]);
				nav_q[1] <= $signed(nrm_rd_q[31:16]);
				nav_q[2] <= $signed(nrm_rd_q[47:32]);
				ncnt_q   <= nrm_rd_q[55:48];
			end
			S_FADD: begin
				fsign_q <= fsum[63];
				drem_q  <= (48'(fmag) << 1) + 48'(fden);
				dden_q  <= 48'(fden) << 15;
				dquo_q  <= '0;
			end
			S_FDIV: begin
				if (dge) drem_q <= drem_q - dden_q;
				dden_q <= dden_q >> 1;
				dquo_q <= dquo_nx;
				if (step_q == DIV_LAST)
					nav_q[comp_q] <= fsign_q ? -q16 : q16;
			end
			default: ;
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= '0;
			comp_q       <= '0;
			vtx_q        <= '0;
			pos_q        <= 1'b1;
			pend_q       <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			if (cfg_valid)
				pos_q <= cfg_data;
			if (result_valid && !result_stall && state_q != S_EMIT)
				result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						unique case (item.action)
							mnva_pkg::ACT_TRI: begin
								if (idx_ok(item.corner_a) && idx_ok(item.corner_b)
										&& idx_ok(item.corner_c))
									state_q <= S_RD_A;
							end
							mnva_pkg::ACT_READ: state_q <= S_RD_OUT;
							default: ;
						endcase
					end
				end
				S_RD_OUT: begin
					pend_q.result_kind <= mnva_pkg::KIND_READ;
					pend_q.is_line     <= 1'b0;
					if (idx_ok(item_q.vertex_index)) begin
						pend_q.normal_x    <= $signed(nrm_rd_q[15:0]);
						pend_q.normal_y    <= $signed(nrm_rd_q[31:16]);
						pend_q.normal_z    <= $signed(nrm_rd_q[47:32]);
						pend_q.share_count <= nrm_rd_q[55:48];
					end else begin
						pend_q.normal_x    <= '0;
						pend_q.normal_y    <= '0;
						pend_q.normal_z    <= '0;
						pend_q.share_count <= '0;
					end
					state_q <= S_EMIT;
				end
				S_RD_A:   state_q <= S_RD_B;
				S_RD_B:   state_q <= S_RD_C;
				S_RD_C:   state_q <= S_LOAD_C;
				S_LOAD_C: state_q <= S_EDGE;
				S_EDGE:   state_q <= S_ESHIFT;
				S_ESHIFT: begin
					step_q  <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					step_q <= step_q + 5'd1;
					if (step_q == CROSS_LAST) state_q <= S_CMAG;
				end
				S_CMAG: state_q <= S_CSHIFT;
				S_CSHIFT: begin
					if (cor[61:30] == '0) begin
						step_q  <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (step_q == SQ_LAST) begin
						step_q  <= '0;
						state_q <= S_SQRT;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				S_SQRT: begin
					step_q <= step_q + 5'd1;
					if (step_q == SQRT_LAST) begin
						comp_q  <= '0;
						state_q <= S_DSET;
					end
				end
				S_DSET: begin
					step_q <= '0;
					if (sroot_q == '0) begin
						vtx_q   <= '0;
						state_q <= S_FRD;
					end else begin
						state_q <= S_DRUN;
					end
				end
				S_DRUN: begin
					step_q <= step_q + 5'd1;
					if (step_q == DIV_LAST) begin
						comp_q <= comp_q + 2'd1;
						if (comp_q == 2'd2) begin
							vtx_q   <= '0;
							state_q <= S_FRD;
						end else begin
							state_q <= S_DSET;
						end
					end
				end
				S_FRD: state_q <= S_FCAP;
				S_FCAP: begin
					comp_q  <= '0;
					state_q <= S_FMUL;
				end
				S_FMUL: state_q <= S_FADD;
				S_FADD: begin
					step_q  <= '0;
					state_q <= S_FDIV;
				end
				S_FDIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == DIV_LAST) begin
						comp_q  <= comp_q + 2'd1;
						state_q <= (comp_q == 2'd2) ? S_FWR : S_FMUL;
					end
				end
				S_FWR: begin
					vtx_q <= vtx_q + 2'd1;
					if (vtx_q == 2'd2) begin
						pend_q.result_kind <= mnva_pkg::KIND_FACE;
						pend_q.normal_x    <= face_q[0];
						pend_q.normal_y    <= face_q[1];
						pend_q.normal_z    <= face_q[2];
						pend_q.is_line     <= line_q;
						pend_q.share_count <= '0;
						state_q            <= S_EMIT;
					end else begin
						state_q <= S_FRD;
					end
				end
				S_EMIT: begin
					if (!result_valid || !result_stall) begin
						result       <= pend_q;
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
